>>> rtl/ssb_pkg.sv
// shared constants, types and tables of the single-sideband frequency shifter
// hilbert coefficients, quarter-wave sine table, cell control struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ssb_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 18;
  localparam int SINE_BITS    = 18;
  localparam int TAP_COUNT    = 100;
  localparam int HALF_TAPS    = TAP_COUNT / 2;
  localparam int TAP_BITS     = $clog2(TAP_COUNT);
  localparam int HALF_BITS    = $clog2(HALF_TAPS);
  // delay of the direct path is TAP_COUNT-1, an odd delay held in the odd half of a cell
  localparam int DIRECT_CELL  = (TAP_COUNT - 2) / 2;
  localparam int SINE_ENTRIES = 1024;
  localparam int IDX_BITS     = $clog2(SINE_ENTRIES);
  localparam int QUARTER      = SINE_ENTRIES / 4;
  localparam int QTAB_BITS    = $clog2(QUARTER);
  localparam int FRAC_BITS    = 22;
  localparam int PHASE_BITS   = 32;
  localparam int INTERP_BITS  = 26;
  localparam int INV_HALF_PI  = 83443;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_STEP = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_SLOPE  = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [SINE_BITS-1:0]   sine_t;
  typedef logic [SINE_BITS-1:0]          qsine_tab_t [QUARTER];

  typedef struct packed {
    logic load;     // new sample enters, line moves one delay
    logic rotate;   // even half circulates toward cell zero
  } cell_ctl_t;

  localparam logic [COEF_BITS-1:0] HALF_COEF [HALF_TAPS] = '{
    18'd106,   18'd111,   18'd118,   18'd128,   18'd142,
    18'd158,   18'd178,   18'd201,   18'd227,   18'd258,
    18'd293,   18'd332,   18'd375,   18'd423,   18'd476,
    18'd535,   18'd598,   18'd668,   18'd743,   18'd825,
    18'd915,   18'd1011,  18'd1115,  18'd1228,  18'd1351,
    18'd1483,  18'd1627,  18'd1782,  18'd1952,  18'd2137,
    18'd2339,  18'd2560,  18'd2804,  18'd3075,  18'd3376,
    18'd3715,  18'd4098,  18'd4537,  18'd5044,  18'd5639,
    18'd6350,  18'd7216,  18'd8300,  18'd9701,  18'd11592,
    18'd14298, 18'd18517, 18'd26066, 18'd43601, 18'd131042
  };

  // odd-symmetric coefficient of one tap
  function automatic coef_t tap_coef(input logic [TAP_BITS-1:0] tap);
    logic [TAP_BITS-1:0] mirror;
    mirror = TAP_BITS'(TAP_COUNT - 1) - tap;
    if (tap < TAP_BITS'(HALF_TAPS)) begin
      return coef_t'(HALF_COEF[tap[HALF_BITS-1:0]]);
    end
    return -coef_t'(HALF_COEF[mirror[HALF_BITS-1:0]]);
  endfunction

  // quarter-wave sine, q30 taylor series rounded to q1.17, built at elaboration
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    logic [63:0] x, x2, term;
    logic signed [63:0] sum, q;
    for (int k = 0; k < QUARTER; k++) begin
      x = (64'(k) * TWO_PI_Q30) / SINE_ENTRIES;
      x2 = (x * x) >> 30;
      term = x;
      sum = signed'(x);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q = (sum + 64'sd4096) >>> 13;
      tab[k] = (q > 64'sd131071) ? 18'd131071 : q[SINE_BITS-1:0];
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

  // full-circle sine entry from quarter-wave symmetry
  function automatic sine_t sine_at(input logic [IDX_BITS-1:0] j);
    logic [IDX_BITS:0] jj, k;
    logic neg;
    logic [SINE_BITS-1:0] mag;
    jj = {1'b0, j};
    neg = 1'b0;
    if (jj <= (IDX_BITS+1)'(QUARTER)) begin
      k = jj;
    end else if (jj <= (IDX_BITS+1)'(2 * QUARTER)) begin
      k = (IDX_BITS+1)'(2 * QUARTER) - jj;
    end else if (jj <= (IDX_BITS+1)'(3 * QUARTER)) begin
      k = jj - (IDX_BITS+1)'(2 * QUARTER);
      neg = 1'b1;
    end else begin
      k = (IDX_BITS+1)'(4 * QUARTER) - jj;
      neg = 1'b1;
    end
    // the peak entry lands on the cap
    mag = (k == (IDX_BITS+1)'(QUARTER)) ? SINE_BITS'((1 << (SINE_BITS - 1)) - 1)
                                         : QSINE[k[QTAB_BITS-1:0]];
    return neg ? -sine_t'(mag) : sine_t'(mag);
  endfunction

endpackage
`default_nettype wire

>>> rtl/ssb_cell.sv
// one cell of the sample line: holds an even and an odd delay
// depends on ssb_pkg
`timescale 1ns / 1ps
`default_nettype none
module ssb_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ssb_pkg::cell_ctl_t ctl,
  input  wire ssb_pkg::sample_t  load_in,
  input  wire ssb_pkg::sample_t  rot_in,
  output ssb_pkg::sample_t       even,
  output ssb_pkg::sample_t       odd
);

  always_ff @(posedge clk) begin
    if (rst) begin
      even <= '0;
      odd  <= '0;
    end else if (ctl.load) begin
      even <= load_in;
      odd  <= even;
    end else if (ctl.rotate) begin
      even <= rot_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ssb_interp.sv
// sine and cosine by 4-point cubic interpolation, one multiply per step
// depends on ssb_pkg
`timescale 1ns / 1ps
`default_nettype none
module ssb_interp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [ssb_pkg::PHASE_BITS-1:0]  phase,
  output logic                                 done,
  output logic signed [ssb_pkg::SAMPLE_BITS-1:0] sine_val,
  output logic signed [ssb_pkg::SAMPLE_BITS-1:0] cosine_val
);

  localparam int W  = ssb_pkg::INTERP_BITS;
  localparam int PW = W + ssb_pkg::FRAC_BITS + 1;

  typedef enum logic [8:0] {
    I_IDLE  = 9'b000000001,
    I_FETCH = 9'b000000010,
    I_LIN   = 9'b000000100,
    I_MUL1  = 9'b000001000,
    I_ADD1  = 9'b000010000,
    I_MUL2  = 9'b000100000,
    I_ADD2  = 9'b001000000,
    I_MUL3  = 9'b010000000,
    I_FIN   = 9'b100000000
  } istate_t;

  istate_t state;
  logic [2:0] cnt;
  logic sel;
  logic [ssb_pkg::IDX_BITS-1:0] ip;
  logic [ssb_pkg::FRAC_BITS-1:0] frac;
  ssb_pkg::sine_t pts [8];
  logic signed [W-1:0] t;
  logic signed [PW-1:0] p;
  logic [ssb_pkg::IDX_BITS-1:0] addr;
  logic signed [W-1:0] a, b, c, d;
  logic signed [ssb_pkg::FRAC_BITS:0] fr;
  logic signed [W-1:0] r22, r23;

  // cosine points start a quarter table further on
  assign addr = (cnt[2] ? ip + ssb_pkg::IDX_BITS'(ssb_pkg::QUARTER) : ip)
              + ssb_pkg::IDX_BITS'(cnt[1:0]);
  assign a = W'(sel ? pts[4] : pts[0]);
  assign b = W'(sel ? pts[5] : pts[1]);
  assign c = W'(sel ? pts[6] : pts[2]);
  assign d = W'(sel ? pts[7] : pts[3]);
  assign fr = signed'({1'b0, frac});
  assign r22 = W'((p + PW'(1 << 21)) >>> 22);
  assign r23 = W'((p + PW'(1 << 22)) >>> 23);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= I_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
      sel   <= 1'b0;
    end else begin
      unique case (state)
        I_IDLE: begin
          if (start) begin
            state <= I_FETCH;
            done  <= 1'b0;
            cnt   <= '0;
            sel   <= 1'b0;
          end
        end
        I_FETCH: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            state <= I_LIN;
          end
        end
        I_LIN:  state <= I_MUL1;
        I_MUL1: state <= I_ADD1;
        I_ADD1: state <= I_MUL2;
        I_MUL2: state <= I_ADD2;
        I_ADD2: state <= I_MUL3;
        I_MUL3: state <= I_FIN;
        I_FIN: begin
          if (sel) begin
            state <= I_IDLE;
            done  <= 1'b1;
          end else begin
            sel   <= 1'b1;
            state <= I_LIN;
          end
        end
        default: state <= I_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == I_IDLE && start) begin
      ip   <= phase[ssb_pkg::FRAC_BITS +: ssb_pkg::IDX_BITS];
      frac <= phase[ssb_pkg::FRAC_BITS-1:0];
    end
    if (state == I_FETCH) begin
      pts[cnt] <= ssb_pkg::sine_at(addr);
    end
    if (state == I_LIN) begin
      t <= W'(3) * (b - c) - a + d;
    end
    if (state == I_MUL1 || state == I_MUL2 || state == I_MUL3) begin
      p <= PW'(t) * PW'(fr);
    end
    if (state == I_ADD1) begin
      t <= r22 + (W'(4) * c + W'(2) * a - W'(5) * b - d);
    end
    if (state == I_ADD2) begin
      t <= r22 + (c - a);
    end
    if (state == I_FIN) begin
      if (sel) begin
        cosine_val <= ssb_pkg::SAMPLE_BITS'(b + r23);
      end else begin
        sine_val <= ssb_pkg::SAMPLE_BITS'(b + r23);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/single_sideband_frequency_shifter_core.sv
// top level of the single-sideband frequency shifter
// uses ssb_pkg, a row of ssb_cell and one ssb_interp
`timescale 1ns / 1ps
`default_nettype none
// usage
// - input stream s_*: one signed q1.23 audio sample per request in s_tdata
// - output stream m_*: one result per input, down-shifted and up-shifted
//   samples, both saturated q1.23
// - cfg_we/cfg_index/cfg_data write target_step (index 0) and step_slope
//   (index 1); write only while no sample is in flight
// - the sample line is a row of 100 cells, each holding an even and an odd
//   delay; the even halves circulate through the shared hilbert mac, one tap
//   per cycle, and are back in place once every tap has been visited
// - m_tvalid rises once the mac loop, scaling and mixing are through and the
//   output register is free
// - a new sample is taken only after the previous one has passed the 100-tap
//   mac loop, scaling, mixing and output; sine/cosine interpolation runs beside the mac
// - s_tready is high only while the core waits for a sample; a finished result
//   waiting in the output register does not block the next sample
// - if the receiver stalls, the next result waits in the output state until the
//   output register frees
// - reset (synchronous, active high) clears the sample line, phase, ramp,
//   configuration and control state; no clearing pass is needed
module single_sideband_frequency_shifter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // sample_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // up_shifted, down_shifted
  input  wire logic        cfg_we,
  input  wire logic [ssb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [ssb_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int TAPS = ssb_pkg::TAP_COUNT;
  localparam int SB   = ssb_pkg::SAMPLE_BITS;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MAC   = 8'b00000010,
    S_FLUSH = 8'b00000100,
    S_H     = 8'b00001000,
    S_HS    = 8'b00010000,
    S_HSR   = 8'b00100000,
    S_MIX   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;
  logic accept;

  // configuration
  logic [30:0] target_step;
  logic signed [31:0] step_slope;

  // phase and ramp
  logic [ssb_pkg::PHASE_BITS-1:0] phase_accumulator;
  logic [31:0] current_step;
  logic [31:0] current_step_next;
  logic signed [32:0] slope_ext;
  logic [32:0] mag, step_up;
  logic signed [33:0] step_dn;

  // sample line
  ssb_pkg::cell_ctl_t cell_ctl;
  ssb_pkg::sample_t even [TAPS];
  ssb_pkg::sample_t odd  [TAPS];

  // hilbert mac and scaling
  logic [ssb_pkg::TAP_BITS-1:0] tap;
  logic signed [41:0] prod;
  logic prod_valid;
  logic signed [47:0] acc;
  logic signed [31:0] h;
  logic signed [49:0] hp;
  logic signed [31:0] hs;

  // mixing
  logic interp_done;
  logic signed [SB-1:0] sn, cs;
  logic signed [55:0] rm1;
  logic signed [47:0] rm2;
  logic signed [57:0] diff, summ;
  logic signed [SB-1:0] down_val, up_val, down_shifted, up_shifted;
  logic out_free;

  function automatic logic signed [SB-1:0] round_sat(input logic signed [57:0] v);
    logic signed [57:0] r;
    r = (v + 58'sd131072) >>> 18;
    if (r > 58'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (r < -58'sd8388608) begin
      return 24'sh800000;
    end
    return r[SB-1:0];
  endfunction

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {up_shifted, down_shifted};

  assign cell_ctl.load   = accept;
  assign cell_ctl.rotate = (state == S_MAC);

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    ssb_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (cell_ctl),
      .load_in ((k == 0) ? ssb_pkg::sample_t'(s_tdata) : odd[(k + TAPS - 1) % TAPS]),
      .rot_in  (even[(k + 1) % TAPS]),
      .even    (even[k]),
      .odd     (odd[k])
    );
  end

  ssb_interp u_interp (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .phase      (phase_accumulator),
    .done       (interp_done),
    .sine_val   (sn),
    .cosine_val (cs)
  );

  // ramp of the phase increment toward the target, sign of the slope ignored
  always_comb begin
    slope_ext = 33'(step_slope);
    mag       = slope_ext[32] ? 33'(-slope_ext) : 33'(slope_ext);
    step_up   = {1'b0, current_step} + mag;
    step_dn   = signed'({2'b00, current_step}) - signed'({1'b0, mag});
    if (current_step < {1'b0, target_step}) begin
      current_step_next = (step_up > {2'b00, target_step}) ? {1'b0, target_step}
                                                           : step_up[31:0];
    end else begin
      current_step_next = (step_dn < signed'({3'b000, target_step})) ? {1'b0, target_step}
                                                                     : step_dn[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_step <= '0;
      step_slope  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssb_pkg::REG_TARGET_STEP: target_step <= cfg_data[30:0];
        ssb_pkg::REG_STEP_SLOPE:  step_slope  <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      tap               <= '0;
      prod_valid        <= 1'b0;
      phase_accumulator <= '0;
      current_step      <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      prod_valid <= (state == S_MAC);
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state             <= S_MAC;
            tap               <= '0;
            phase_accumulator <= phase_accumulator + current_step;
            current_step      <= current_step_next;
          end
        end
        S_MAC: begin
          tap <= tap + ssb_pkg::TAP_BITS'(1);
          if (tap == ssb_pkg::TAP_BITS'(TAPS - 1)) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: state <= S_H;
        S_H:     state <= S_HS;
        S_HS:    state <= S_HSR;
        S_HSR:   state <= S_MIX;
        S_MIX: begin
          if (interp_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= 42'(even[0]) * 42'(ssb_pkg::tap_coef(tap));
    if (accept) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + 48'(prod);
    end
    if (state == S_H) begin
      h <= 32'((acc + 48'sd65536) >>> 17);
    end
    if (state == S_HS) begin
      hp <= 50'(h) * 50'(ssb_pkg::INV_HALF_PI);
    end
    if (state == S_HSR) begin
      hs <= 32'((hp + 50'sd65536) >>> 17);
    end
    if (state == S_MIX) begin
      rm1 <= 56'(hs) * 56'(sn);
      rm2 <= 48'(odd[ssb_pkg::DIRECT_CELL]) * 48'(cs);
    end
    if (state == S_OUT && out_free) begin
      down_shifted <= down_val;
      up_shifted   <= up_val;
    end
  end

  assign diff     = 58'(rm2) - 58'(rm1);
  assign summ     = 58'(rm2) + 58'(rm1);
  assign down_val = round_sat(diff);
  assign up_val   = round_sat(summ);

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (tap < ssb_pkg::TAP_BITS'(TAPS)))
    else $error("tap counter beyond last tap");

  a_accept_starts_mac: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_MAC))
    else $error("accepted sample did not start the mac loop");

  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    !current_step[31])
    else $error("phase increment beyond target range");

  a_interp_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> interp_done)
    else $error("mix used sine before interpolation finished");

endmodule
`default_nettype wire
